[src/lfd_pkg.sv]
// Shared types, constants and the CRC-8 step function of the lidar frame deframer.
package lfd_pkg;

  localparam int unsigned POINTS_DEF = 12;
  localparam int unsigned HDR_LEN = 5;
  localparam int unsigned TAG_POS = 4;
  localparam int unsigned FIRST_PT_ADDR = 5;

  localparam logic [7:0] HDR_FIRST = 8'h54;
  localparam logic [7:0] HDR_SECOND = 8'h2C;
  localparam logic [7:0] CRC_POLY = 8'h4D;

  localparam int unsigned ANGLE_W = 9;
  localparam logic [ANGLE_W-1:0] ANGLE_STEP = 9'd30;
  localparam logic [ANGLE_W-1:0] ANGLE_WRAP = 9'd360;

  localparam logic STATUS_POINT = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_LO,
    EM_HI,
    EM_INT,
    EM_LOAD,
    EM_ERR
  } em_state_t;

  typedef struct packed {
    logic       start;
    logic       crc_err;
    logic [7:0] tag;
    logic       new_scan;
  } emit_cmd_t;

  // One byte through CRC-8, MSB first, not reflected.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[src/lfd_store.sv]
// Frame byte store: one write port, one read port with registered read data.
module lfd_store #(
  parameter int unsigned DEPTH = 43,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/lfd_emit.sv]
// Point read-out sequencer and result output register.
module lfd_emit #(
  parameter int unsigned POINTS_PER_FRAME = lfd_pkg::POINTS_DEF,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lfd_pkg::emit_cmd_t           cmd,
  output logic                         busy,
  output logic                         rd_en,
  output logic [ADDR_W-1:0]            rd_addr,
  input  logic [7:0]                   rd_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic [lfd_pkg::ANGLE_W-1:0]  out_angle_index,
  output logic [15:0]                  out_distance_mm,
  output logic [7:0]                   out_intensity,
  output logic [7:0]                   out_frame_tag,
  output logic                         out_new_scan,
  output logic                         out_last_of_frame
);
  import lfd_pkg::*;

  localparam int unsigned PT_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
  localparam logic [PT_W-1:0] LAST_PT = PT_W'(POINTS_PER_FRAME - 1);

  em_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]  addr_r;
  logic [PT_W-1:0]    point_r;
  logic [ANGLE_W-1:0] angle_r;
  logic [ANGLE_W-1:0] angle_sum;
  logic [7:0]         tag_r;
  logic               ns_r;
  logic [7:0]         lo_r;
  logic [7:0]         hi_r;
  logic               out_free;
  logic               last_pt;
  logic               load_pt;
  logic               load_err;

  logic               out_valid_r;
  logic               out_status_r;
  logic [ANGLE_W-1:0] out_angle_r;
  logic [15:0]        out_dist_r;
  logic [7:0]         out_int_r;
  logic [7:0]         out_tag_r;
  logic               out_ns_r;
  logic               out_last_r;

  assign out_free = !out_valid_r || !out_stall;
  assign last_pt  = (point_r == LAST_PT);
  assign angle_sum = angle_r + ANGLE_STEP;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EM_IDLE: begin
        if (cmd.start) begin
          state_nxt = cmd.crc_err ? EM_ERR : EM_LO;
        end
      end
      EM_LO:   state_nxt = EM_HI;
      EM_HI:   state_nxt = EM_INT;
      EM_INT:  state_nxt = EM_LOAD;
      EM_LOAD: begin
        if (out_free) begin
          state_nxt = last_pt ? EM_IDLE : EM_LO;
        end
      end
      EM_ERR: begin
        if (out_free) begin
          state_nxt = EM_IDLE;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    rd_en    = 1'b0;
    load_pt  = 1'b0;
    load_err = 1'b0;
    unique case (state_r)
      EM_IDLE: busy = 1'b0;
      EM_LO, EM_HI, EM_INT: rd_en = 1'b1;
      EM_LOAD: load_pt = out_free;
      EM_ERR:  load_err = out_free;
      default: busy = 1'b1;
    endcase
  end

  assign rd_addr = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_pt || load_err) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == EM_IDLE && cmd.start) begin
      addr_r  <= ADDR_W'(FIRST_PT_ADDR);
      point_r <= '0;
      angle_r <= '0;
      tag_r   <= cmd.tag;
      ns_r    <= cmd.new_scan;
    end
    if (rd_en) begin
      addr_r <= addr_r + 1'b1;
    end
    if (state_r == EM_HI) begin
      lo_r <= rd_data;
    end
    if (state_r == EM_INT) begin
      hi_r <= rd_data;
    end
    if (load_pt) begin
      out_status_r <= STATUS_POINT;
      out_angle_r  <= angle_r;
      out_dist_r   <= {hi_r, lo_r};
      out_int_r    <= rd_data;
      out_tag_r    <= tag_r;
      out_ns_r     <= ns_r;
      out_last_r   <= last_pt;
      point_r      <= point_r + 1'b1;
      angle_r      <= (angle_sum >= ANGLE_WRAP) ? angle_sum - ANGLE_WRAP : angle_sum;
    end
    if (load_err) begin
      out_status_r <= STATUS_CRC_ERR;
      out_angle_r  <= '0;
      out_dist_r   <= '0;
      out_int_r    <= '0;
      out_tag_r    <= tag_r;
      out_ns_r     <= 1'b0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_angle_index   = out_angle_r;
  assign out_distance_mm   = out_dist_r;
  assign out_intensity     = out_int_r;
  assign out_frame_tag     = out_tag_r;
  assign out_new_scan      = out_ns_r;
  assign out_last_of_frame = out_last_r;

endmodule

[src/lidar_frame_deframer_crc8.sv]
// Top level of the lidar frame deframer with CRC-8 check.
//
// Usage: feed received serial bytes on the in_ channel (in_valid, in_stall,
// in_rx_byte). The block hunts for the header 0x54 0x2C, stores the frame of
// 5 + 3*POINTS_PER_FRAME + 2 bytes, all but its last byte, in a byte memory
// and runs a CRC-8 (poly 0x4D, init 0) over all bytes but the last.
// Bytes are taken whenever the read-out sequencer is idle.
// On the frame's final byte the CRC is compared. A match starts a read-out of
// the stored points: each point passes through the states EM_LO, EM_HI,
// EM_INT and EM_LOAD (three reads of the single memory read port, one load
// of the output register). A mismatch moves the sequencer to EM_ERR, which
// presents one error item through the output register.
// in_stall is high while the read-out runs; it drops as soon as the last
// item sits in the output register, even if it has not yet been taken.
// out_stall holds the output register and makes the read-out sequencer wait
// in EM_LOAD or EM_ERR; input then stays stalled until the burst continues.
// Reset (rst_n low, synchronous) clears the hunt position, the running CRC,
// the last accepted tag and the output valid; memory contents are not cleared.
module lidar_frame_deframer_crc8 #(
  parameter int unsigned POINTS_PER_FRAME = lfd_pkg::POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic [lfd_pkg::ANGLE_W-1:0]  out_angle_index,
  output logic [15:0]                  out_distance_mm,
  output logic [7:0]                   out_intensity,
  output logic [7:0]                   out_frame_tag,
  output logic                         out_new_scan,
  output logic                         out_last_of_frame
);
  import lfd_pkg::*;

  localparam int unsigned FRAME_BYTES = HDR_LEN + 3 * POINTS_PER_FRAME + 2;
  localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);
  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(FRAME_BYTES - 1);

  // Hunt and CRC state.
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [7:0]        tag_r, tag_nxt;
  logic [7:0]        last_tag_r, last_tag_nxt;

  logic              acc;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              emit_busy;
  emit_cmd_t         cmd;

  // Take a byte only while the read-out sequencer is idle.
  assign in_stall = emit_busy;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    tag_nxt      = tag_r;
    last_tag_nxt = last_tag_r;
    wr_en        = 1'b0;
    wr_addr      = pos_r;
    cmd          = '0;
    if (acc) begin
      if (pos_r == '0) begin
        // Hunt: drop everything but the first header byte.
        if (in_rx_byte == HDR_FIRST) begin
          wr_en   = 1'b1;
          pos_nxt = ADDR_W'(1);
          crc_nxt = crc8_update(8'h00, in_rx_byte);
        end
      end else if (pos_r == ADDR_W'(1)) begin
        if (in_rx_byte == HDR_SECOND) begin
          wr_en   = 1'b1;
          pos_nxt = ADDR_W'(2);
          crc_nxt = crc8_update(crc_r, in_rx_byte);
        end else if (in_rx_byte == HDR_FIRST) begin
          // Restart on a fresh first header byte.
          wr_en   = 1'b1;
          wr_addr = '0;
          pos_nxt = ADDR_W'(1);
          crc_nxt = crc8_update(8'h00, in_rx_byte);
        end else begin
          pos_nxt = '0;
          crc_nxt = '0;
        end
      end else if (pos_r < LAST_POS) begin
        wr_en   = 1'b1;
        pos_nxt = pos_r + 1'b1;
        crc_nxt = crc8_update(crc_r, in_rx_byte);
        if (pos_r == ADDR_W'(TAG_POS)) begin
          tag_nxt = in_rx_byte;
        end
      end else begin
        pos_nxt = '0;
        crc_nxt = '0;
        if (pos_r == LAST_POS) begin
          // Checksum byte: launch the read-out or the error item.
          cmd.start    = 1'b1;
          cmd.crc_err  = (crc_r != in_rx_byte);
          cmd.tag      = tag_r;
          cmd.new_scan = (tag_r != last_tag_r);
          if (crc_r == in_rx_byte) begin
            last_tag_nxt = tag_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= '0;
      last_tag_r <= '0;
    end else begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      last_tag_r <= last_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  lfd_store #(
    .DEPTH  (FRAME_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lfd_emit #(
    .POINTS_PER_FRAME (POINTS_PER_FRAME),
    .ADDR_W           (ADDR_W)
  ) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .busy              (emit_busy),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_angle_index   (out_angle_index),
    .out_distance_mm   (out_distance_mm),
    .out_intensity     (out_intensity),
    .out_frame_tag     (out_frame_tag),
    .out_new_scan      (out_new_scan),
    .out_last_of_frame (out_last_of_frame)
  );

  // Checksum byte always hands the frame to the sequencer, which then holds input.
  a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    acc && pos_r == LAST_POS |=> in_stall)
    else $error("final byte did not start the read-out");

  // Position never leaves the frame.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("byte position out of range");

  // An error item is always the sole and last item of its frame.
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_CRC_ERR |-> out_last_of_frame && out_angle_index == '0)
    else $error("malformed CRC error item");

  // A non-header byte while hunting leaves the hunt idle.
  a_hunt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    acc && pos_r == '0 && in_rx_byte != HDR_FIRST |=> pos_r == '0)
    else $error("hunt advanced on a non-header byte");

endmodule

[bench/lfd_frame_checker.sv]
// Frame tracker and item comparator for the lidar frame deframer.
`timescale 1ns / 100ps
module lfd_frame_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_status,
  input  logic [lfd_pkg::ANGLE_W-1:0] out_angle_index,
  input  logic [15:0]                 out_distance_mm,
  input  logic [7:0]                  out_intensity,
  input  logic [7:0]                  out_frame_tag,
  input  logic                        out_new_scan,
  input  logic                        out_last_of_frame,
  output int unsigned                 fail_count,
  output int unsigned                 pending_count
);
  import lfd_pkg::*;

  localparam int FRAME_BYTES = HDR_LEN + 3 * POINTS_DEF + 2;
  localparam int CRC_POS = FRAME_BYTES - 1;

  typedef struct packed {
    logic               status;
    logic [ANGLE_W-1:0] angle;
    logic [15:0]        distance;
    logic [7:0]         inten;
    logic [7:0]         tag;
    logic               new_scan;
    logic               last;
  } point_item_t;

  logic [7:0]   frame_bytes [FRAME_BYTES];
  int unsigned  hunt_pos;
  logic [7:0]   crc_acc;
  logic [7:0]   prev_tag;
  point_item_t  points_due[$];
  int unsigned  mismatches = 0;

  function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] r;
    r = acc ^ d;
    repeat (8) r = (r << 1) ^ (r[7] ? CRC_POLY : 8'h00);
    return r;
  endfunction

  task automatic open_frame(input logic [7:0] b);
    frame_bytes[0] = b;
    crc_acc = crc_next(8'h00, b);
    hunt_pos = 1;
  endtask

  // Advance the frame tracker by one byte; queue the items a frame end produces.
  task automatic deframe_byte(input logic [7:0] b);
    point_item_t it;
    logic [7:0]  tag;
    int unsigned base;
    if (hunt_pos == 0) begin
      if (b == HDR_FIRST) open_frame(b);
    end else if (hunt_pos == 1) begin
      if (b == HDR_SECOND) begin
        frame_bytes[1] = b;
        crc_acc = crc_next(crc_acc, b);
        hunt_pos = 2;
      end else if (b == HDR_FIRST) begin
        open_frame(b);
      end else begin
        hunt_pos = 0;
        crc_acc = 8'h00;
      end
    end else if (hunt_pos < CRC_POS) begin
      frame_bytes[hunt_pos] = b;
      crc_acc = crc_next(crc_acc, b);
      hunt_pos++;
    end else begin
      tag = frame_bytes[TAG_POS];
      hunt_pos = 0;
      if (crc_acc != b) begin
        it.status = STATUS_CRC_ERR;
        it.angle = '0;
        it.distance = '0;
        it.inten = '0;
        it.tag = tag;
        it.new_scan = 1'b0;
        it.last = 1'b1;
        points_due.push_back(it);
      end else begin
        for (int i = 0; i < POINTS_DEF; i++) begin
          base = FIRST_PT_ADDR + 3 * i;
          it.status = STATUS_POINT;
          it.angle = ANGLE_W'((ANGLE_STEP * i) % ANGLE_WRAP);
          it.distance = {frame_bytes[base + 1], frame_bytes[base]};
          it.inten = frame_bytes[base + 2];
          it.tag = tag;
          it.new_scan = (tag != prev_tag);
          it.last = (i == POINTS_DEF - 1);
          points_due.push_back(it);
        end
        prev_tag = tag;
      end
      crc_acc = 8'h00;
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    point_item_t want;
    if (!rst_n) begin
      hunt_pos = 0;
      crc_acc = 8'h00;
      prev_tag = 8'h00;
      points_due.delete();
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual status %0h angle %0d tag %0h",
                   $time, out_status, out_angle_index, out_frame_tag);
          mismatches++;
        end else begin
          want = points_due.pop_front();
          check_field("status", want.status, out_status);
          check_field("angle_index", want.angle, out_angle_index);
          check_field("distance_mm", want.distance, out_distance_mm);
          check_field("intensity", want.inten, out_intensity);
          check_field("frame_tag", want.tag, out_frame_tag);
          check_field("new_scan", want.new_scan, out_new_scan);
          check_field("last_of_frame", want.last, out_last_of_frame);
        end
      end
    end
    fail_count <= mismatches;
    pending_count <= points_due.size();
  end

endmodule

[bench/tb_lidar_frame_deframer_crc8.sv]
// Testbench top for the lidar frame deframer: byte stimulus, channel pacing and verdict.
`timescale 1ns / 100ps
module tb_lidar_frame_deframer_crc8;
  import lfd_pkg::*;

  localparam int FRAME_BYTES = HDR_LEN + 3 * POINTS_DEF + 2;
  // Total bytes offered over the whole run, directed part included.
  localparam int TOTAL_BYTES = 350;
  // Last stretch of the random part runs with no gaps on either side.
  localparam int CALM_BYTES = 60;
  localparam int LONG_HOLD = 300;
  // Covers the slowest burst, pipeline included, with margin.
  localparam int DRAIN_CYCLES = 4 * POINTS_DEF + 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_status;
  logic [ANGLE_W-1:0] out_angle_index;
  logic [15:0]        out_distance_mm;
  logic [7:0]         out_intensity;
  logic [7:0]         out_frame_tag;
  logic               out_new_scan;
  logic               out_last_of_frame;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  bit          long_hold_req = 1'b0;
  logic [7:0]  cur_tag;

  lidar_frame_deframer_crc8 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_angle_index   (out_angle_index),
    .out_distance_mm   (out_distance_mm),
    .out_intensity     (out_intensity),
    .out_frame_tag     (out_frame_tag),
    .out_new_scan      (out_new_scan),
    .out_last_of_frame (out_last_of_frame)
  );

  lfd_frame_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_angle_index   (out_angle_index),
    .out_distance_mm   (out_distance_mm),
    .out_intensity     (out_intensity),
    .out_frame_tag     (out_frame_tag),
    .out_new_scan      (out_new_scan),
    .out_last_of_frame (out_last_of_frame),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  always #4 clk = ~clk;

  // Watchdog: count cycles in which neither channel moves an item; a stuck
  // handshake or a missing result ends the run here.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_lidar_frame_deframer_crc8 failed");
      $finish;
    end
  end

  // Receiver pacing: exactly one assignment of out_stall per falling edge.
  // A pending long-hold request takes priority over the short random bursts.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // CRC-8 for building frames: poly from the package, init 0, MSB first.
  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] r;
    r = acc ^ d;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) r = {r[6:0], 1'b0} ^ CRC_POLY;
      else r = {r[6:0], 1'b0};
    end
    return r;
  endfunction

  // Offer one byte; called and returning at a falling edge. Insert an
  // optional gap first, then hold the byte until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Build a full frame with the header, tag, points and a trailing CRC, then
  // send its first `keep` bytes. A nonzero crc_flip corrupts the checksum.
  task automatic send_frame(input logic [7:0] tag, input fill_t fill,
                            input logic [7:0] crc_flip, input int keep);
    logic [7:0] fr [FRAME_BYTES];
    logic [7:0] crc;
    crc = 8'h00;
    for (int k = 0; k < FRAME_BYTES - 1; k++) begin
      if (k == 0) fr[k] = HDR_FIRST;
      else if (k == 1) fr[k] = HDR_SECOND;
      else if (k == TAG_POS) fr[k] = tag;
      else if (k >= FIRST_PT_ADDR && k < FIRST_PT_ADDR + 3 * POINTS_DEF && fill != FILL_RANDOM)
        fr[k] = (fill == FILL_ZERO) ? 8'h00 : 8'hFF;
      else fr[k] = 8'($urandom);
      crc = crc_fold(crc, fr[k]);
    end
    fr[FRAME_BYTES - 1] = crc ^ crc_flip;
    for (int k = 0; k < keep; k++) send_byte(fr[k]);
  endtask

  initial begin
    int  pick;
    bit  held;
    held = 1'b0;

    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part.
    // Drop stray bytes while hunting, including a lone second header byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_SECOND);
    // Bad second header byte: restart the hunt.
    send_byte(HDR_FIRST);
    send_byte(8'h13);
    // Repeated first header byte: the second one opens the frame. Tag 0
    // matches the cleared last tag, so no new scan; all-zero points.
    send_byte(HDR_FIRST);
    send_frame(8'h00, FILL_ZERO, 8'h00, FRAME_BYTES);
    // New tag with all-ones points: new scan, full-scale distance.
    send_frame(8'hFF, FILL_ONES, 8'h00, FRAME_BYTES);
    // Same tag again: no new scan.
    send_frame(8'hFF, FILL_RANDOM, 8'h00, FRAME_BYTES);
    // CRC mismatch: a single error item; the last tag must stay put.
    send_frame(8'h11, FILL_RANDOM, 8'h01, FRAME_BYTES);
    send_frame(8'hFF, FILL_RANDOM, 8'h00, FRAME_BYTES);
    send_frame(8'h3C, FILL_RANDOM, 8'h80, FRAME_BYTES);

    // Random part: mostly well-formed frames with random content, some
    // corrupted checksums, cut-short frames, broken headers and noise.
    cur_tag = 8'hFF;
    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= TOTAL_BYTES - CALM_BYTES) begin
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
      end
      if ($urandom_range(0, 1) == 1) cur_tag = 8'($urandom);
      pick = $urandom_range(0, 99);
      // Once, at the start of the random part: ask the receiver for a long
      // hold and push a good frame into it so the burst backs up into the
      // input side.
      if (!held && bytes_sent >= TOTAL_BYTES / 3) begin
        long_hold_req = 1'b1;
        held = 1'b1;
        pick = 0;
      end
      if (pick < 65) begin
        send_frame(cur_tag, FILL_RANDOM, 8'h00, FRAME_BYTES);
      end else if (pick < 80) begin
        send_frame(cur_tag, FILL_RANDOM, 8'($urandom_range(1, 255)), FRAME_BYTES);
      end else if (pick < 88) begin
        send_frame(cur_tag, FILL_RANDOM, 8'h00, $urandom_range(2, FRAME_BYTES - 1));
      end else if (pick < 94) begin
        send_byte(HDR_FIRST);
        send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every queued item, then let any late item show up.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_lidar_frame_deframer_crc8 passed");
    end else begin
      $display("tb_lidar_frame_deframer_crc8 failed");
    end
    $finish;
  end

endmodule
